>>> sv/knn_pkg.sv
package knn_pkg;

    localparam int FEAT_W  = 16;
    localparam int PRICE_W = 32;
    localparam int PRED_W  = 48;
    localparam int DIST_W  = 36;

    typedef enum logic [1:0] {
        MODE_TRAIN = 2'd0,
        MODE_QUERY = 2'd1,
        MODE_CLEAR = 2'd2,
        MODE_NONE  = 2'd3
    } t_mode;

    localparam logic [0:0] REG_K  = 1'b0;
    localparam logic [0:0] REG_NF = 1'b1;

    localparam logic STATUS_OK    = 1'b0;
    localparam logic STATUS_SHORT = 1'b1;

endpackage

>>> sv/knn_regression_predictor.sv
// k-nearest-neighbor regression predictor.
// Input channel (i_valid/o_ready) carries one beat per feature element with
// i_mode: training element, query element, clear or none. A training row's price
// rides on its last element; a none beat is accepted and ignored.
// The last query element starts a search: every stored row is read back one
// feature per cycle through a single shared subtract/square/accumulate unit.
// Its distance then walks a sorted k-best list one slot per cycle, and state
// S_SUM_RD steps to the next row. Then the k best rows' prices are summed from
// the price memory, and the serial divider is started, waited on and its result
// registered. o_ready is low from the accepting beat until the result is
// registered. The output channel (o_valid/i_ready) holds a result until it
// is taken; a training or clear beat is accepted while the result waits, but
// any query beat waits until it is taken.
// Fewer stored rows than k gives status 1 and price 0 on the next cycle.
// Reset (synchronous, active low) empties the store and restores k=1 and
// feature_count=8. Users must write configuration over the APB port only
// while idle; the block itself does not enforce it.
module knn_regression_predictor #(
    parameter int MAX_ROWS     = 256,
    parameter int MAX_FEATURES = 8,
    parameter int MAX_K        = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_mode,
    input  logic signed [15:0] i_feature_value,
    input  logic signed [31:0] i_row_price,
    output logic        o_valid,
    input  logic        i_ready,
    output logic signed [47:0] o_predicted_price,
    output logic [0:0]  o_status,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int RW   = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int FW   = (MAX_FEATURES > 1) ? $clog2(MAX_FEATURES) : 1;
    localparam int KW   = (MAX_K > 1) ? $clog2(MAX_K) : 1;
    localparam int CW   = $clog2(MAX_ROWS + 1);
    localparam int KCW  = $clog2(MAX_K + 1);
    localparam int SUMW = 32 + KCW + 1;
    localparam int FDEP = MAX_ROWS * MAX_FEATURES;
    localparam int FAW  = (FDEP > 1) ? $clog2(FDEP) : 1;
    localparam int DW   = knn_pkg::DIST_W + FW;

    typedef enum logic [3:0] {
        S_IDLE, S_RD, S_ACC, S_INS, S_SUM_RD, S_SUM, S_DSTART, S_DIV, S_WAIT, S_OUT
    } t_state;

    t_state r_state;
    logic [4:0] r_k;
    logic [3:0] r_nf;
    logic [CW-1:0] r_rows;
    logic [FW:0]   r_pos;

    // Effective values after clamping.
    logic [KCW-1:0] w_k;
    logic [FW:0]    w_nf;
    always_comb begin
        if (r_k == 5'd0) w_k = KCW'(1);
        else if (32'(r_k) > MAX_K) w_k = KCW'(MAX_K);
        else w_k = KCW'(r_k);
        if (r_nf == 4'd0) w_nf = (FW+1)'(1);
        else if (32'(r_nf) > MAX_FEATURES) w_nf = (FW+1)'(MAX_FEATURES);
        else w_nf = (FW+1)'(r_nf);
    end

    logic w_in_acc, w_last, w_full;
    assign w_in_acc = i_valid && o_ready;
    assign w_last   = (r_pos + 1'b1) >= w_nf;
    assign w_full   = 32'(r_rows) >= MAX_ROWS;

    // Query buffer, read at a sequencer-chosen index but only 1 read port.
    logic signed [15:0] r_qbuf [MAX_FEATURES];

    // Search sequencer registers.
    logic [RW-1:0]  r_row;
    logic [FW-1:0]  r_fi;
    logic [DW-1:0]  r_dist;
    logic [KCW-1:0] r_filled;
    logic [KCW-1:0] r_j;
    logic [DW-1:0]  r_bd [MAX_K];
    logic [RW-1:0]  r_br [MAX_K];
    logic [KCW-1:0] r_si;
    logic signed [SUMW-1:0] r_sum;
    logic           r_sumv;
    logic [47:0]    r_pred;
    logic           r_stat;
    logic           r_ovalid;
    logic signed [15:0] r_qsel;

    // Memories.
    logic           w_fwe;
    logic [FAW-1:0] w_fwa, w_fra;
    logic [15:0]    w_frd;
    logic [RW-1:0]  w_pra;
    logic [31:0]    w_prd;

    assign w_fwe = w_in_acc && i_mode == knn_pkg::MODE_TRAIN && !w_full;
    assign w_fwa = FAW'(r_rows[RW-1:0] * MAX_FEATURES + r_pos[FW-1:0]);
    assign w_fra = FAW'(r_row * MAX_FEATURES + r_fi);
    assign w_pra = r_br[r_si[KW-1:0]];

    knn_ram #(.WIDTH(16), .DEPTH(FDEP)) u_feat (
        .i_clk(i_clk), .i_we(w_fwe), .i_waddr(w_fwa), .i_wdata(i_feature_value),
        .i_raddr(w_fra), .o_rdata(w_frd)
    );
    knn_ram #(.WIDTH(32), .DEPTH(MAX_ROWS)) u_price (
        .i_clk(i_clk), .i_we(w_fwe && w_last), .i_waddr(r_rows[RW-1:0]),
        .i_wdata(i_row_price), .i_raddr(w_pra), .o_rdata(w_prd)
    );

    // Shared unit: one difference squared per cycle.
    logic signed [16:0] w_diff;
    logic [33:0]        w_sq;
    assign w_diff = 17'(signed'(w_frd)) - 17'(r_qsel);
    assign w_sq   = 34'(w_diff * w_diff);

    // Divider over |sum| * 65536.
    logic        w_dstart, w_ddone;
    logic [63:0] w_dnum, w_dq;
    logic [SUMW-1:0] w_mag;
    assign w_mag  = r_sum[SUMW-1] ? SUMW'(-r_sum) : SUMW'(r_sum);
    assign w_dnum = {16'(0), 48'(w_mag)} << 16;
    // The divider starts in S_DSTART, once the last price has been added to the sum.
    assign w_dstart = (r_state == S_DSTART);
    knn_divider #(.NUM_W(64), .DEN_W(KCW)) u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(w_dstart), .i_num(w_dnum),
        .i_den(w_k), .o_done(w_ddone), .o_quot(w_dq)
    );

    logic [KW-1:0] w_ji, w_jp;
    assign w_ji = r_j[KW-1:0];
    assign w_jp = KW'(r_j - 1'b1);

    assign o_ready = (r_state == S_IDLE) && !(r_ovalid && i_mode == knn_pkg::MODE_QUERY);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_k      <= 5'd1;
            r_nf     <= 4'd8;
            r_rows   <= '0;
            r_pos    <= '0;
            r_ovalid <= 1'b0;
            r_sumv   <= 1'b0;
        end else begin
            if (psel && penable && pwrite) begin
                if (paddr[2] == knn_pkg::REG_K) r_k <= pwdata[4:0];
                else r_nf <= pwdata[3:0];
            end
            if (o_valid && i_ready) r_ovalid <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (w_in_acc) begin
                        case (i_mode)
                            knn_pkg::MODE_CLEAR: begin
                                r_rows <= '0;
                                r_pos  <= '0;
                            end
                            knn_pkg::MODE_TRAIN: begin
                                if (w_last) begin
                                    r_pos <= '0;
                                    if (!w_full) r_rows <= r_rows + 1'b1;
                                end else begin
                                    r_pos <= r_pos + 1'b1;
                                end
                            end
                            knn_pkg::MODE_QUERY: begin
                                r_qbuf[r_pos[FW-1:0]] <= i_feature_value;
                                if (w_last) begin
                                    r_pos <= '0;
                                    if (r_rows < CW'(w_k)) begin
                                        r_pred   <= '0;
                                        r_stat   <= knn_pkg::STATUS_SHORT;
                                        r_ovalid <= 1'b1;
                                    end else begin
                                        r_row    <= '0;
                                        r_fi     <= '0;
                                        r_filled <= '0;
                                        r_state  <= S_RD;
                                    end
                                end else begin
                                    r_pos <= r_pos + 1'b1;
                                end
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                S_RD: begin
                    // Feature read issued this cycle; data lands next cycle.
                    r_dist  <= '0;
                    r_qsel  <= r_qbuf[r_fi];
                    r_fi    <= r_fi + 1'b1;
                    r_state <= S_ACC;
                end
                S_ACC: begin
                    r_dist <= r_dist + DW'(w_sq);
                    if ((FW+1)'(r_fi) == w_nf ||
                        (r_fi == '0 && w_nf == (FW+1)'(MAX_FEATURES))) begin
                        r_state <= S_INS;
                        r_j     <= (r_filled < w_k) ? r_filled : KCW'(w_k - 1'b1);
                    end else begin
                        r_qsel <= r_qbuf[r_fi];
                        r_fi   <= r_fi + 1'b1;
                    end
                end
                S_INS: begin
                    if (r_filled == w_k && r_dist >= r_bd[KW'(w_k - 1'b1)]) begin
                        r_state <= S_SUM_RD;
                    end else if (r_j != '0 && r_bd[w_jp] > r_dist) begin
                        r_bd[w_ji] <= r_bd[w_jp];
                        r_br[w_ji] <= r_br[w_jp];
                        r_j        <= r_j - 1'b1;
                    end else begin
                        r_bd[w_ji] <= r_dist;
                        r_br[w_ji] <= r_row;
                        if (r_filled < w_k) r_filled <= r_filled + 1'b1;
                        r_state <= S_SUM_RD;
                    end
                end
                S_SUM_RD: begin
                    // Next row, or start summing when all rows are done.
                    if (CW'(r_row) + 1'b1 >= r_rows) begin
                        r_si    <= '0;
                        r_sum   <= '0;
                        r_sumv  <= 1'b0;
                        r_state <= S_SUM;
                    end else begin
                        r_row   <= r_row + 1'b1;
                        r_fi    <= '0;
                        r_state <= S_RD;
                    end
                end
                S_SUM: begin
                    // r_si addresses the price RAM; its data arrives in the next cycle.
                    if (r_sumv) r_sum <= r_sum + SUMW'(signed'(w_prd));
                    if (r_si == w_k) begin
                        if (r_sumv) begin
                            r_state <= S_DSTART;
                        end
                        r_sumv <= 1'b1;
                    end else begin
                        r_sumv <= 1'b1;
                        r_si   <= r_si + 1'b1;
                    end
                end
                S_DSTART: begin
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    if (w_ddone) begin
                        r_pred  <= r_sum[SUMW-1] ? 48'(-w_dq) : w_dq[47:0];
                        r_stat  <= knn_pkg::STATUS_OK;
                        r_state <= S_WAIT;
                    end
                end
                S_WAIT: begin
                    if (!r_ovalid) begin
                        r_ovalid <= 1'b1;
                        r_state  <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_valid           = r_ovalid;
    assign o_predicted_price = r_pred;
    assign o_status          = r_stat;
    assign pready            = 1'b1;
    assign prdata            = (paddr[2] == knn_pkg::REG_K) ? {27'd0, r_k} : {28'd0, r_nf};

endmodule

>>> sv/knn_ram.sv
module knn_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> sv/knn_divider.sv
// Restoring divider: one quotient bit a cycle, magnitude only; sign applied outside.
module knn_divider #(
    parameter int NUM_W = 64,
    parameter int DEN_W = 7
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    output logic             o_done,
    output logic [NUM_W-1:0] o_quot
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [NUM_W-1:0] r_quot;
    logic [DEN_W:0]   r_rem;
    logic [DEN_W-1:0] r_den;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic             r_done;
    logic [DEN_W:0]   w_trial;

    assign w_trial = {r_rem[DEN_W-1:0], r_quot[NUM_W-1]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(NUM_W);
                r_quot <= i_num;
                r_rem  <= '0;
                r_den  <= i_den;
            end else if (r_busy) begin
                if (w_trial >= {1'b0, r_den}) begin
                    r_rem  <= w_trial - {1'b0, r_den};
                    r_quot <= {r_quot[NUM_W-2:0], 1'b1};
                end else begin
                    r_rem  <= w_trial;
                    r_quot <= {r_quot[NUM_W-2:0], 1'b0};
                end
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule

>>> sv/knn_checker.sv
module knn_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_valid,
    input logic        i_ready,
    input logic [47:0] o_predicted_price,
    input logic [0:0]  o_status,
    input logic        pready
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_predicted_price) && $stable(o_status))
        else $error("result changed while stalled");

    a_short_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status == 1'b1 |-> o_predicted_price == 48'd0)
        else $error("short status with nonzero price");

    a_pready: assert property (@(posedge i_clk) disable iff (!i_rst_n) pready)
        else $error("pready low");

    a_reset_idle: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("result after reset");

endmodule

bind knn_regression_predictor knn_checker u_knn_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n),
    .o_valid(o_valid), .i_ready(i_ready), .o_predicted_price(o_predicted_price),
    .o_status(o_status), .pready(pready)
);

>>> verif/knn_regression_predictor_test.sv
module knn_regression_predictor_test;

    localparam int ROWS_CAP  = 256;
    localparam int FEAT_CAP  = 8;
    localparam int K_CAP     = 16;
    localparam int IDLE_LIMIT = 40000;

    typedef logic signed [knn_pkg::FEAT_W-1:0]  t_feat;
    typedef logic signed [knn_pkg::PRICE_W-1:0] t_price;
    typedef logic signed [knn_pkg::PRED_W-1:0]  t_pred;

    typedef struct packed {
        t_pred price;
        logic  status;
    } t_estimate;

    typedef struct {
        knn_pkg::t_mode mode;
        t_feat          fv;
        t_price         price;
        bit             typed;
        t_pred          e_price;
        logic           e_status;
    } t_vector;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic o_ready;
    logic [1:0] i_mode = knn_pkg::MODE_NONE;
    t_feat i_feature_value = '0;
    t_price i_row_price = '0;
    logic o_valid;
    logic i_ready = 1'b0;
    t_pred o_predicted_price;
    logic [0:0] o_status;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [2:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;

    knn_regression_predictor uut (.*);

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Shadow state of the predictor.
    logic [4:0] cfg_k = 5'd1;
    logic [3:0] cfg_nf = 4'd8;
    t_feat feat_mem [ROWS_CAP][FEAT_CAP];
    bit feat_set [ROWS_CAP][FEAT_CAP];
    t_price price_mem [ROWS_CAP];
    t_feat qbuf [FEAT_CAP];
    bit qset [FEAT_CAP];
    int rows_held = 0;
    int elem_pos = 0;

    t_estimate estimate_q [$];
    int mismatches = 0;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    bit hold_go = 1'b0;
    bit hold_seen = 1'b0;
    int hold_left = 0;
    int idle_cycles = 0;

    function automatic int k_used();
        if (cfg_k < 1) return 1;
        if (cfg_k > K_CAP) return K_CAP;
        return cfg_k;
    endfunction

    function automatic int nf_used();
        if (cfg_nf < 1) return 1;
        if (cfg_nf > FEAT_CAP) return FEAT_CAP;
        return cfg_nf;
    endfunction

    function automatic t_estimate nearest_mean();
        longint unsigned best_d [K_CAP];
        int best_r [K_CAP];
        int k;
        int nf;
        int filled;
        int j;
        longint unsigned d;
        longint diff;
        longint sum;
        t_estimate res;
        k = k_used();
        nf = nf_used();
        filled = 0;
        sum = 0;
        res.price = '0;
        res.status = knn_pkg::STATUS_SHORT;
        if (rows_held < k) return res;
        for (int r = 0; r < rows_held; r++) begin
            d = 0;
            for (int i = 0; i < nf; i++) begin
                diff = longint'(feat_mem[r][i]) - longint'(qbuf[i]);
                d += longint'(diff * diff);
            end
            if (filled == k && d >= best_d[k-1]) continue;
            if (filled < k) begin
                j = filled;
                filled++;
            end else begin
                j = k - 1;
            end
            while (j > 0 && best_d[j-1] > d) begin
                best_d[j] = best_d[j-1];
                best_r[j] = best_r[j-1];
                j--;
            end
            best_d[j] = d;
            best_r[j] = r;
        end
        for (int i = 0; i < k; i++) sum += longint'(price_mem[best_r[i]]);
        sum = (sum * 65536) / longint'(k);
        res.price = sum[knn_pkg::PRED_W-1:0];
        res.status = knn_pkg::STATUS_OK;
        return res;
    endfunction

    // True when finishing a query now would only read entries already written.
    function automatic bit search_safe(int pos);
        int nf;
        nf = nf_used();
        if (rows_held < k_used()) return 1'b1;
        for (int i = 0; i < nf; i++) begin
            if (!qset[i] && i != pos) return 1'b0;
            for (int r = 0; r < rows_held; r++)
                if (!feat_set[r][i]) return 1'b0;
        end
        return 1'b1;
    endfunction

    // Applies one accepted beat; returns 1 when it produces a result.
    function automatic bit apply_beat(knn_pkg::t_mode m, t_feat fv, t_price price,
                                      output t_estimate res);
        int pos;
        bit last;
        pos = elem_pos % FEAT_CAP;
        res = '0;
        if (m == knn_pkg::MODE_CLEAR) begin
            rows_held = 0;
            elem_pos = 0;
            return 1'b0;
        end
        if (m == knn_pkg::MODE_NONE) return 1'b0;
        last = (elem_pos + 1 >= nf_used());
        if (m == knn_pkg::MODE_TRAIN) begin
            if (rows_held < ROWS_CAP) begin
                feat_mem[rows_held][pos] = fv;
                feat_set[rows_held][pos] = 1'b1;
            end
            if (last) begin
                if (rows_held < ROWS_CAP) begin
                    price_mem[rows_held] = price;
                    rows_held++;
                end
                elem_pos = 0;
            end else begin
                elem_pos++;
            end
            return 1'b0;
        end
        qbuf[pos] = fv;
        qset[pos] = 1'b1;
        if (!last) begin
            elem_pos++;
            return 1'b0;
        end
        elem_pos = 0;
        res = nearest_mean();
        return 1'b1;
    endfunction

    task automatic drive_beat(knn_pkg::t_mode m, t_feat fv, t_price price, bit typed,
                              t_pred e_price, logic e_status);
        t_estimate res;
        i_valid <= 1'b1;
        i_mode <= m;
        i_feature_value <= fv;
        i_row_price <= price;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        if (apply_beat(m, fv, price, res)) begin
            if (typed) begin
                res.price = e_price;
                res.status = e_status;
            end
            estimate_q = {estimate_q, res};
        end
        if ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (estimate_q.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [2:0] addr, logic [31:0] data);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (addr == 3'(4 * knn_pkg::REG_K)) cfg_k = data[4:0];
        else cfg_nf = data[3:0];
    endtask

    task automatic random_beats(int count, int cap);
        knn_pkg::t_mode row_mode;
        knn_pkg::t_mode m;
        int r;
        row_mode = knn_pkg::MODE_TRAIN;
        for (int n = 0; n < count; n++) begin
            if (elem_pos == 0)
                row_mode = ($urandom_range(99) < 70) ? knn_pkg::MODE_TRAIN
                                                      : knn_pkg::MODE_QUERY;
            m = row_mode;
            r = $urandom_range(99);
            if (r < 2) m = knn_pkg::MODE_CLEAR;
            else if (r < 4) m = knn_pkg::MODE_NONE;
            else if (r < 8)
                m = (row_mode == knn_pkg::MODE_TRAIN) ? knn_pkg::MODE_QUERY
                                                       : knn_pkg::MODE_TRAIN;
            if (rows_held >= cap && elem_pos == 0 && $urandom_range(1) == 0)
                m = knn_pkg::MODE_CLEAR;
            if (m == knn_pkg::MODE_QUERY && elem_pos + 1 >= nf_used() &&
                !search_safe(elem_pos % FEAT_CAP))
                m = knn_pkg::MODE_TRAIN;
            drive_beat(m, t_feat'($urandom), t_price'($urandom), 1'b0, '0, 1'b0);
        end
    endtask

    // Output side: checks each result and stalls at random.
    always @(posedge i_clk) begin
        t_estimate want;
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            if (o_valid && i_ready) begin
                if (estimate_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) $display("unexpected result %0d/%0d",
                        o_predicted_price, o_status);
                end else begin
                    want = estimate_q.pop_front();
                    if (want.price !== o_predicted_price || want.status !== o_status) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: expected price %0d status %0d, got %0d %0d",
                                want.price, want.status, o_predicted_price, o_status);
                    end
                end
            end
            if (hold_go && !hold_seen) begin
                hold_seen <= 1'b1;
                hold_left <= 3000;
                i_ready <= 1'b0;
            end else if (hold_left > 0) begin
                hold_left <= hold_left - 1;
                i_ready <= 1'b0;
            end else begin
                i_ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready) || !i_rst_n || psel)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > IDLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    t_vector vectors [] = '{
        '{knn_pkg::MODE_QUERY, 16'sd0,      32'sd0,    1'b0, '0, 1'b0},
        '{knn_pkg::MODE_QUERY, 16'sd0,      32'sd0,    1'b1, '0, knn_pkg::STATUS_SHORT},
        '{knn_pkg::MODE_TRAIN, 16'sh8000,   32'sd0,    1'b0, '0, 1'b0},
        '{knn_pkg::MODE_TRAIN, 16'sh8000,   32'sh7fffffff, 1'b0, '0, 1'b0},
        '{knn_pkg::MODE_TRAIN, 16'sd32767,  32'sd0,    1'b0, '0, 1'b0},
        '{knn_pkg::MODE_TRAIN, 16'sd32767,  32'sh80000000, 1'b0, '0, 1'b0},
        '{knn_pkg::MODE_QUERY, 16'sd32767,  32'sd0,    1'b0, '0, 1'b0},
        '{knn_pkg::MODE_QUERY, 16'sd32767,  32'sd0,    1'b1, 48'sh800000000000,
          knn_pkg::STATUS_OK},
        '{knn_pkg::MODE_QUERY, 16'sh8000,   32'sd0,    1'b0, '0, 1'b0},
        '{knn_pkg::MODE_QUERY, 16'sh8000,   32'sd0,    1'b1, 48'sh7fffffff0000,
          knn_pkg::STATUS_OK},
        '{knn_pkg::MODE_NONE,  16'sd9,      32'sd9,    1'b0, '0, 1'b0},
        '{knn_pkg::MODE_QUERY, 16'sd0,      32'sd0,    1'b0, '0, 1'b0},
        '{knn_pkg::MODE_QUERY, 16'sd5,      32'sd0,    1'b0, '0, 1'b0},
        '{knn_pkg::MODE_CLEAR, 16'sd0,      32'sd0,    1'b0, '0, 1'b0},
        '{knn_pkg::MODE_QUERY, 16'sd1,      32'sd0,    1'b0, '0, 1'b0},
        '{knn_pkg::MODE_QUERY, 16'sd2,      32'sd0,    1'b1, '0, knn_pkg::STATUS_SHORT},
        '{knn_pkg::MODE_TRAIN, 16'sd100,    32'sd0,    1'b0, '0, 1'b0},
        '{knn_pkg::MODE_QUERY, 16'sd7,      32'sd55,   1'b1, '0, knn_pkg::STATUS_SHORT},
        '{knn_pkg::MODE_TRAIN, 16'sd1,      32'sd0,    1'b0, '0, 1'b0},
        '{knn_pkg::MODE_TRAIN, 16'sd2,      32'sd1000, 1'b0, '0, 1'b0},
        '{knn_pkg::MODE_TRAIN, 16'sd1,      32'sd0,    1'b0, '0, 1'b0},
        '{knn_pkg::MODE_TRAIN, 16'sd2,      32'sd1000, 1'b0, '0, 1'b0},
        '{knn_pkg::MODE_QUERY, 16'sd1,      32'sd0,    1'b0, '0, 1'b0},
        '{knn_pkg::MODE_QUERY, 16'sd2,      32'sd0,    1'b1, 48'sd65536000,
          knn_pkg::STATUS_OK}
    };

    // Per phase: k, feature count, row cap, beats, sender idle %, receiver stall %.
    int phase_k []     = '{0,  31, 3,  16, 5,  2};
    int phase_nf []    = '{15, 0,  4,  8,  3,  6};
    int phase_cap []   = '{8,  40, 20, 24, 30, 16};
    int phase_beats [] = '{150, 200, 250, 200, 250, 200};
    int phase_gap []   = '{0,  64, 0,  20, 0,  20};
    int phase_stall [] = '{0,  0,  64, 20, 0,  20};

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        write_reg(3'(4 * knn_pkg::REG_NF), 32'd2);
        foreach (vectors[v])
            drive_beat(vectors[v].mode, vectors[v].fv, vectors[v].price, vectors[v].typed,
                       vectors[v].e_price, vectors[v].e_status);
        drain();
        foreach (phase_k[p]) begin
            write_reg(3'(4 * knn_pkg::REG_K), 32'(phase_k[p]));
            write_reg(3'(4 * knn_pkg::REG_NF), 32'(phase_nf[p]));
            send_idle_pct = phase_gap[p];
            recv_stall_pct = phase_stall[p];
            // Stored rows may lack features that a larger count now reads.
            drive_beat(knn_pkg::MODE_CLEAR, '0, '0, 1'b0, '0, 1'b0);
            if (p == 3) begin
                random_beats(phase_beats[p] / 2, phase_cap[p]);
                hold_go = 1'b1;
                random_beats(phase_beats[p] / 2, phase_cap[p]);
            end else begin
                random_beats(phase_beats[p], phase_cap[p]);
            end
            drain();
        end
        // Fill the store past its size with one feature per row.
        send_idle_pct = 0;
        recv_stall_pct = 20;
        write_reg(3'(4 * knn_pkg::REG_K), 32'd16);
        write_reg(3'(4 * knn_pkg::REG_NF), 32'd1);
        drive_beat(knn_pkg::MODE_CLEAR, '0, '0, 1'b0, '0, 1'b0);
        for (int n = 0; n < ROWS_CAP + 4; n++)
            drive_beat(knn_pkg::MODE_TRAIN, t_feat'($urandom), t_price'($urandom),
                       1'b0, '0, 1'b0);
        repeat (3) drive_beat(knn_pkg::MODE_QUERY, t_feat'($urandom), '0, 1'b0, '0, 1'b0);
        drain();
        repeat (200) @(posedge i_clk);
        if (mismatches == 0 && estimate_q.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

>>> knn_regression_predictor.f
sv/knn_pkg.sv
sv/knn_ram.sv
sv/knn_divider.sv
sv/knn_regression_predictor.sv
sv/knn_checker.sv
verif/knn_regression_predictor_test.sv
